### hw/rtl/mmas_pkg.sv
package mmas_pkg;

  // operation codes carried by req_type; the unused code behaves as add
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_DBL = 2'd2;

  // configuration register indexes
  localparam int          CFG_IDX_W      = 3;
  localparam int          MOD_REGS       = 7;
  localparam logic [2:0]  REG_WORD_COUNT = 3'd7;
  localparam logic [2:0]  WORD_COUNT_RST = 3'd4;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FIX  = 5'b00010,
    S_CMP  = 5'b00100,
    S_SUB  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  // control of the shared word adder
  typedef struct packed {
    logic sub;   // 1: a - b - cin (borrow), 0: a + b + cin
    logic cin;
  } alu_ctrl_t;

endpackage

### hw/rtl/mmas_alu.sv
module mmas_alu #(
  parameter int WORD_BITS = 64
) (
  input  logic [WORD_BITS-1:0] a,
  input  logic [WORD_BITS-1:0] b,
  input  mmas_pkg::alu_ctrl_t  ctrl,
  output logic [WORD_BITS-1:0] sum,
  output logic                 cout
);
  import mmas_pkg::*;

  logic [WORD_BITS:0] ext;

  always_comb begin
    if (ctrl.sub) begin
      ext = {1'b0, a} - {1'b0, b} - {{WORD_BITS{1'b0}}, ctrl.cin};
    end else begin
      ext = {1'b0, a} + {1'b0, b} + {{WORD_BITS{1'b0}}, ctrl.cin};
    end
  end

  // top bit is the carry for add and the borrow for subtract
  assign sum  = ext[WORD_BITS-1:0];
  assign cout = ext[WORD_BITS];

endmodule

### hw/rtl/multiword_modular_add_sub.sv
// channel   dir  handshake                    payload
// req       in   req_valid / req_stall        req_type, x_word, y_word
// result    out  result_valid / result_stall  result_word, result_last, reduce_capped
// cfg       in   cfg_valid / cfg_ready        cfg_index, cfg_data
//
// Operand words are taken one per cycle while req_stall is low; every pass runs in the
// one shared word adder. After the final word: one correction pass (carry or borrow
// case), or compare passes that scan down from the top word, with up to MAX_REDUCE_STEPS
// subtract passes between them; then the words are handed out, held by result stalls.
// req_stall is high from the final word until the last result word is in the output
// register. Synchronous reset clears control and modulus; result words are not cleared.
module multiword_modular_add_sub #(
  parameter int WORD_BITS        = 64,
  parameter int MAX_WORDS        = 7,
  parameter int MAX_REDUCE_STEPS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [1:0]                      req_type,
  input  logic [63:0]                     x_word,
  input  logic [63:0]                     y_word,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [63:0]                     result_word,
  output logic                            result_last,
  output logic                            reduce_capped,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mmas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                     cfg_data
);
  import mmas_pkg::*;

  localparam int IDX_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CNT_W  = $clog2(MAX_WORDS + 1);
  localparam int MOD_N  = (MAX_WORDS < MOD_REGS) ? MAX_WORDS : MOD_REGS;
  localparam int MIDX_W = (MOD_N > 1) ? $clog2(MOD_N) : 1;
  localparam int STEP_W = $clog2(MAX_REDUCE_STEPS + 1);

  // configuration
  logic [WORD_BITS-1:0] mod_reg [MOD_N];
  logic [2:0]           word_count;

  // operation state
  state_t               state, state_next;
  logic [WORD_BITS-1:0] result_store [MAX_WORDS];
  logic [IDX_W-1:0]     word_index;
  logic                 carry_flag;
  logic [1:0]           op_held;
  logic [IDX_W-1:0]     ptr;
  logic [CNT_W-1:0]     len;
  logic [STEP_W-1:0]    steps;
  logic                 capped_flag;

  // output register
  logic [WORD_BITS-1:0] out_word;

  // shared adder
  logic [WORD_BITS-1:0] alu_a, alu_b, alu_sum;
  alu_ctrl_t            alu_ctrl;
  logic                 alu_cout;

  logic                 req_xfer, out_free;
  logic [1:0]           op_cur;
  logic [2:0]           wc_min;
  logic [CNT_W-1:0]     n_act;
  logic [CNT_W-1:0]     ptr_ext;
  logic                 ptr_last, word_final;
  logic [WORD_BITS-1:0] x_in, y_in, store_rd, mod_rd;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE);
  assign req_xfer  = req_valid && !req_stall;
  assign out_free  = !result_valid || !result_stall;

  assign x_in     = x_word[WORD_BITS-1:0];
  assign y_in     = y_word[WORD_BITS-1:0];
  assign store_rd = result_store[ptr];
  assign mod_rd   = mod_reg[ptr[MIDX_W-1:0]];
  assign ptr_ext  = CNT_W'(ptr);
  assign ptr_last = (ptr_ext + CNT_W'(1)) == len;

  assign op_cur = (word_index == '0) ? req_type : op_held;

  // active word count: zero acts as one, saturate at the storage depth
  always_comb begin
    wc_min = (word_count == 3'd0) ? 3'd1 : word_count;
    if (int'(wc_min) > MOD_N) begin
      n_act = CNT_W'(MOD_N);
    end else begin
      n_act = CNT_W'(wc_min);
    end
  end

  assign word_final = (CNT_W'(word_index) + CNT_W'(1)) >= n_act;

  // operand selection for the shared adder
  always_comb begin
    alu_a    = store_rd;
    alu_b    = mod_rd;
    alu_ctrl = '{sub: 1'b1, cin: carry_flag};
    case (state)
      S_IDLE: begin
        alu_a        = x_in;
        alu_b        = (op_cur == OP_DBL) ? x_in : y_in;
        alu_ctrl.sub = (op_cur == OP_SUB);
        alu_ctrl.cin = (word_index == '0) ? 1'b0 : carry_flag;
      end
      S_FIX: begin
        // borrow out of subtract: add the modulus back; carry otherwise: take it off
        alu_ctrl.sub = (op_held != OP_SUB);
      end
      S_CMP: begin
        alu_ctrl.cin = 1'b0;
      end
      default: begin
      end
    endcase
  end

  mmas_alu #(
    .WORD_BITS (WORD_BITS)
  ) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .ctrl (alu_ctrl),
    .sum  (alu_sum),
    .cout (alu_cout)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_xfer && word_final) begin
          state_next = alu_cout ? S_FIX : S_CMP;
        end
      end
      S_FIX: begin
        if (ptr_last) begin
          state_next = S_EMIT;
        end
      end
      S_CMP: begin
        if (alu_cout) begin
          state_next = S_EMIT;
        end else if (alu_sum != '0 || ptr == '0) begin
          state_next = (int'(steps) >= MAX_REDUCE_STEPS) ? S_EMIT : S_SUB;
        end
      end
      S_SUB: begin
        if (ptr_last) begin
          state_next = S_CMP;
        end
      end
      S_EMIT: begin
        if (out_free && ptr_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      foreach (mod_reg[i]) mod_reg[i] <= '0;
      word_count   <= WORD_COUNT_RST;
      word_index   <= '0;
      carry_flag   <= 1'b0;
      op_held      <= OP_ADD;
      steps        <= '0;
      capped_flag  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready && cfg_index == REG_WORD_COUNT) begin
        word_count <= cfg_data[2:0];
      end
      if (cfg_valid && cfg_ready && int'(cfg_index) < MOD_N) begin
        mod_reg[cfg_index[MIDX_W-1:0]] <= cfg_data[WORD_BITS-1:0];
      end
      if (state == S_EMIT && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_xfer) begin
            op_held <= op_cur;
            if (word_final) begin
              word_index  <= '0;
              carry_flag  <= 1'b0;
              steps       <= '0;
              capped_flag <= 1'b0;
            end else begin
              word_index <= word_index + IDX_W'(1);
              carry_flag <= alu_cout;
            end
          end
        end
        S_FIX, S_SUB: begin
          carry_flag <= ptr_last ? 1'b0 : alu_cout;
          if (state == S_SUB && ptr_last) begin
            steps <= steps + STEP_W'(1);
          end
        end
        S_CMP: begin
          if (!alu_cout && (alu_sum != '0 || ptr == '0) &&
              int'(steps) >= MAX_REDUCE_STEPS) begin
            capped_flag <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_xfer) begin
          result_store[word_index] <= alu_sum;
          if (word_final) begin
            len <= n_act;
            ptr <= alu_cout ? '0 : IDX_W'(n_act - CNT_W'(1));
          end
        end
      end
      S_FIX: begin
        result_store[ptr] <= alu_sum;
        ptr <= ptr_last ? '0 : ptr + IDX_W'(1);
      end
      S_CMP: begin
        // scan from the top word down; move down only while words match, else return to word zero
        if (alu_cout || alu_sum != '0 || ptr == '0) begin
          ptr <= '0;
        end else begin
          ptr <= ptr - IDX_W'(1);
        end
      end
      S_SUB: begin
        result_store[ptr] <= alu_sum;
        ptr <= ptr_last ? IDX_W'(len - CNT_W'(1)) : ptr + IDX_W'(1);
      end
      S_EMIT: begin
        if (out_free) begin
          out_word      <= store_rd;
          result_last   <= ptr_last;
          reduce_capped <= capped_flag;
          ptr           <= ptr + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign result_word = 64'(out_word);

`ifndef SYNTH
  a_ptr_in_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (CNT_W'(ptr) < len))
    else $error("word pointer beyond operand length");

  a_steps_capped: assert property (@(posedge clk) disable iff (rst)
    int'(steps) <= MAX_REDUCE_STEPS)
    else $error("reduction step count over cap");

  a_fix_not_capped: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == S_FIX && state == S_EMIT) |-> !capped_flag)
    else $error("cap flag set after single correction");

  a_no_emit_overrun: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free && ptr_last) |=> (state == S_IDLE))
    else $error("emit did not end on last word");
`endif

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import mmas_pkg::*;

  localparam int MAX_WORDS        = 7;
  localparam int MAX_REDUCE_STEPS = 8;
  localparam int WIDE             = 64 * MAX_WORDS;
  localparam int RAND_ITEMS       = 320;
  localparam int SETTLE           = 200;
  localparam int CYCLE_LIMIT      = 400000;
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [63:0] word;
    logic        last;
    logic        capped;
  } result_t;

  // Tracks the word-serial sum and the modulus reduction, and holds the result
  // words still owed by the block.
  class modsum_board;
    logic [63:0] modulus [MOD_REGS];
    logic [2:0]  word_count;
    logic [63:0] partial [MAX_WORDS];
    int          word_pos;
    logic        carry;
    logic [1:0]  op;
    result_t     words_due [$];
    int          errors;

    function new();
      foreach (modulus[i]) modulus[i] = '0;
      foreach (partial[i]) partial[i] = '0;
      word_count = WORD_COUNT_RST;
      word_pos   = 0;
      carry      = 1'b0;
      op         = OP_ADD;
      errors     = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] data);
      if (idx == REG_WORD_COUNT) word_count = data[2:0];
      else modulus[idx] = data;
    endfunction

    function void note_request(logic [1:0] kind, logic [63:0] x, logic [63:0] y);
      int              n;
      int              steps;
      logic [63:0]     addend;
      logic [64:0]     s;
      logic [WIDE-1:0] acc;
      logic [WIDE-1:0] md;
      logic [WIDE-1:0] mask;
      logic            capped;
      result_t         r;
      n = (word_count == 3'd0) ? 1 : int'(word_count);
      // only the code on the first word of an operation counts
      if (word_pos == 0) begin
        op    = kind;
        carry = 1'b0;
      end
      if (op == OP_SUB) begin
        partial[word_pos] = x - y - 64'(carry);
        carry = (y > x) || (carry && (y == x));
      end else begin
        addend = (op == OP_DBL) ? x : y;
        s = {1'b0, x} + {1'b0, addend} + 65'(carry);
        partial[word_pos] = s[63:0];
        carry = s[64];
      end
      if (word_pos + 1 < n) begin
        word_pos++;
        return;
      end

      acc  = '0;
      md   = '0;
      mask = '0;
      for (int i = 0; i < n; i++) begin
        acc[i*64 +: 64]  = partial[i];
        md[i*64 +: 64]   = modulus[i];
        mask[i*64 +: 64] = '1;
      end
      capped = 1'b0;
      if (carry) begin
        // one correction, wrapping at the operand width
        if (op == OP_SUB) acc = (acc + md) & mask;
        else acc = (acc - md) & mask;
      end else begin
        steps = 0;
        while (steps < MAX_REDUCE_STEPS && acc >= md) begin
          acc = acc - md;
          steps++;
        end
        capped = (acc >= md);
      end
      for (int i = 0; i < n; i++) begin
        r.word   = acc[i*64 +: 64];
        r.last   = (i == n - 1);
        r.capped = capped;
        words_due.push_back(r);
      end
      word_pos = 0;
      carry    = 1'b0;
    endfunction

    function void check_result(logic [63:0] w, logic l, logic c);
      result_t want;
      if (words_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: word %h last %b capped %b", w, l, c);
        return;
      end
      want = words_due.pop_front();
      if (want.word !== w || want.last !== l || want.capped !== c) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: expected word %h last %b capped %b, got %h %b %b",
                   want.word, want.last, want.capped, w, l, c);
      end
    endfunction
  endclass

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        req_valid    = 1'b0;
  logic        req_stall;
  logic [1:0]  req_type     = OP_ADD;
  logic [63:0] x_word       = '0;
  logic [63:0] y_word       = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [63:0] result_word;
  logic        result_last;
  logic        reduce_capped;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data     = '0;

  modsum_board sb = new();
  logic [63:0] cfg_mod [MOD_REGS];
  logic [2:0]  cfg_count;
  bit          quiet    = 1'b0;
  bit          hold_off = 1'b0;
  int          cycle_count = 0;

  multiword_modular_add_sub #(
    .WORD_BITS        (64),
    .MAX_WORDS        (MAX_WORDS),
    .MAX_REDUCE_STEPS (MAX_REDUCE_STEPS)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req_type      (req_type),
    .x_word        (x_word),
    .y_word        (y_word),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result_word   (result_word),
    .result_last   (result_last),
    .reduce_capped (reduce_capped),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // observe every transfer at the edge where it happens
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (req_valid && !req_stall) sb.note_request(req_type, x_word, y_word);
      if (result_valid && !result_stall)
        sb.check_result(result_word, result_last, reduce_capped);
    end
  end

  // result side: random stall before each transfer, one long hold on request
  initial begin : result_sink
    int w;
    wait (!rst);
    forever begin
      if (hold_off) begin
        w = 400;
        hold_off = 1'b0;
      end else if (quiet) begin
        w = 0;
      end else begin
        w = $urandom_range(0, 4);
      end
      if (w > 0) begin
        result_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  function automatic logic [63:0] pick_word();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2: v = {32'd0, $urandom};
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // leaves req_valid high so back-to-back words need no extra assignment
  task automatic send_word(input logic [1:0] kind, input logic [63:0] x,
                           input logic [63:0] y);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type  <= kind;
    x_word    <= x;
    y_word    <= y;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic load_config(input logic [7:0] which);
    for (int i = 0; i < 8; i++) begin
      if (which[i]) begin
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IDX_W'(i);
        if (i == REG_WORD_COUNT) cfg_data <= {61'({$urandom, $urandom} >> 3), cfg_count};
        else cfg_data <= cfg_mod[i];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
      end
    end
    cfg_valid <= 1'b0;
  endtask

  // drop valid, wait for every owed word, then keep the bench idle for the settle time
  task automatic drain();
    req_valid <= 1'b0;
    while (sb.words_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin : stimulus
    int sent;
    int phase;
    int len;
    int mode;
    foreach (cfg_mod[i]) cfg_mod[i] = '0;
    cfg_count = WORD_COUNT_RST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: four words, zero modulus, carry out of the top word
    repeat (4) send_word(OP_ADD, '1, '1);
    drain();

    // single word against the all-ones modulus
    cfg_mod[0] = '1;
    cfg_count  = 3'd1;
    load_config(8'h81);
    send_word(OP_ADD, '1, '1);
    send_word(OP_SUB, '0, 64'd1);
    send_word(OP_DBL, '1, pick_word());
    send_word(OP_SPARE, 64'd1, 64'd2);
    send_word(OP_ADD, '1, '0);
    send_word(OP_SUB, 64'd7, 64'd7);
    drain();

    // word count zero acts as one; zero modulus runs to the cap
    cfg_mod[0] = '0;
    cfg_count  = 3'd0;
    load_config(8'h81);
    send_word(OP_ADD, 64'd5, 64'd3);
    send_word(OP_SUB, 64'd2, 64'd1);
    drain();

    // widest operand, tiny modulus
    cfg_mod[0] = 64'd1;
    cfg_count  = 3'd7;
    load_config(8'hFF);
    repeat (7) send_word(OP_ADD, pick_word(), pick_word());
    drain();

    // shrink the word count in the middle of an operation
    cfg_count = 3'd4;
    load_config(8'h80);
    repeat (2) send_word(OP_ADD, pick_word(), pick_word());
    drain();
    cfg_count = 3'd2;
    load_config(8'h80);
    send_word(OP_SUB, pick_word(), pick_word());
    drain();

    sent  = 0;
    phase = 0;
    while (sent < RAND_ITEMS) begin
      mode = $urandom_range(0, 4);
      for (int i = 0; i < MOD_REGS; i++) begin
        case (mode)
          0: cfg_mod[i] = {$urandom, $urandom};
          1: cfg_mod[i] = '1;
          2: cfg_mod[i] = '0;
          3: cfg_mod[i] = (i == 0) ? 64'($urandom_range(1, 16)) : '0;
          default: cfg_mod[i] = pick_word();
        endcase
      end
      cfg_count = 3'($urandom_range(0, 7));
      load_config((phase == 0) ? 8'hFF : 8'($urandom_range(1, 255)));
      quiet = ($urandom_range(0, 3) == 0);
      len = $urandom_range(8, 40);
      if (phase == 2) begin
        quiet    = 1'b0;
        hold_off = 1'b1;
        len      = 40;
      end
      repeat (len) begin
        send_word(2'($urandom_range(0, 3)), pick_word(), pick_word());
        sent++;
      end
      drain();
      phase++;
    end

    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

### sim.f
hw/rtl/mmas_pkg.sv
hw/rtl/mmas_alu.sv
hw/rtl/multiword_modular_add_sub.sv
verif/testbench.sv
